// File: sv/wsa_pkg.sv
// Shared widths, limits and types for the weighted signature agreement block.
`default_nettype none
package wsa_pkg;

    localparam int SIG_W  = 16;
    localparam int SUM_W  = 27;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = $clog2(FRAC_W);

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

    // Request from the accumulator to the serial divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] match;
        logic [SUM_W-1:0] weight;
    } t_div_req;

endpackage
`default_nettype wire

// File: sv/wsa_div.sv
// Bit-serial restoring divider that turns the two sums into the Q0.16 similarity.
`default_nettype none
module wsa_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire wsa_pkg::t_div_req           i_req,
    input  wire                              i_ready,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic [wsa_pkg::FRAC_W-1:0]       o_similarity,
    output logic                             o_zero_weight
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [wsa_pkg::SUM_W-1:0]    r_num;
    logic [wsa_pkg::SUM_W-1:0]    r_den;
    logic [wsa_pkg::SUM_W-1:0]    r_rem;
    logic [wsa_pkg::FRAC_W-1:0]   r_quo;
    logic [wsa_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_zero;

    logic [wsa_pkg::SUM_W:0]      twice;
    logic [wsa_pkg::SUM_W:0]      den_ext;
    logic [wsa_pkg::SUM_W:0]      diff0;
    logic [wsa_pkg::SUM_W:0]      rem2;
    logic [wsa_pkg::SUM_W:0]      rem_sub;
    logic                         rem_ge;

    always_comb begin
        twice   = {r_num, 1'b0};
        den_ext = {1'b0, r_den};
        diff0   = twice - den_ext;
        rem2    = {r_rem, 1'b0};
        rem_sub = rem2 - den_ext;
        rem_ge  = (rem2 >= den_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_zero  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_num   <= i_req.match;
                        r_den   <= i_req.weight;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt  <= '0;
                    r_zero <= 1'b0;
                    if (r_den == '0) begin
                        r_zero  <= 1'b1;
                        r_quo   <= '0;
                        r_state <= S_DONE;
                    end else if (r_num == r_den) begin
                        // Every row agreed: the exact value 1.0 saturates.
                        r_quo   <= wsa_pkg::FRAC_MAX;
                        r_state <= S_DONE;
                    end else if (twice > den_ext) begin
                        r_rem   <= diff0[wsa_pkg::SUM_W-1:0];
                        r_state <= S_DIV;
                    end else begin
                        r_quo   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    // The remainder stays below the divisor, so it fits SUM_W bits.
                    r_rem <= rem_ge ? rem_sub[wsa_pkg::SUM_W-1:0]
                                    : rem2[wsa_pkg::SUM_W-1:0];
                    r_quo <= {r_quo[wsa_pkg::FRAC_W-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == wsa_pkg::CNT_W'(wsa_pkg::FRAC_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_similarity  = r_quo;
    assign o_zero_weight = r_zero;

endmodule
`default_nettype wire

// File: sv/weighted_signature_agreement.sv
// Weighted signature agreement: one row accumulated per cycle, serial divide per signature.
// A result is valid once the divider has passed its setup state and the serial quotient
// steps, or straight after setup when the weight is zero, all rows agree or agreement is at most half.
// Throughput: one row per cycle; a last row waits while the divider still holds the
// previous signature, and the divider then paces the signatures.
// Reset (synchronous, active low) clears both sums and returns the divider to idle.
`default_nettype none
module weighted_signature_agreement (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [wsa_pkg::SIG_W-1:0]       i_sig_a,
    input  wire [wsa_pkg::SIG_W-1:0]       i_sig_b,
    input  wire [wsa_pkg::SIG_W-1:0]       i_cost_a,
    input  wire [wsa_pkg::SIG_W-1:0]       i_cost_b,
    input  wire                            i_last_row,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [wsa_pkg::FRAC_W-1:0]     o_similarity,
    output logic                           o_zero_weight
);

    logic [wsa_pkg::SUM_W-1:0] r_match;
    logic [wsa_pkg::SUM_W-1:0] r_weight;
    logic [wsa_pkg::SUM_W-1:0] n_match;
    logic [wsa_pkg::SUM_W-1:0] n_weight;

    logic [wsa_pkg::SIG_W-1:0] sig_a_c;
    logic [wsa_pkg::SIG_W-1:0] sig_b_c;
    logic [wsa_pkg::SIG_W-1:0] mag_a;
    logic [wsa_pkg::SIG_W-1:0] mag_b;
    logic [wsa_pkg::SIG_W:0]   row_w;
    logic [wsa_pkg::SUM_W:0]   sum_m;
    logic [wsa_pkg::SUM_W:0]   sum_w;
    logic                      agree;
    logic                      xfer;
    logic                      div_busy;
    wsa_pkg::t_div_req         div_req;

    always_comb begin
        sig_a_c = i_sig_a[wsa_pkg::SIG_W-1] ? '0 : i_sig_a;
        sig_b_c = i_sig_b[wsa_pkg::SIG_W-1] ? '0 : i_sig_b;
        // Two's complement negate; the most negative code maps to its magnitude.
        mag_a   = i_cost_a[wsa_pkg::SIG_W-1] ? (~i_cost_a + 1'b1) : i_cost_a;
        mag_b   = i_cost_b[wsa_pkg::SIG_W-1] ? (~i_cost_b + 1'b1) : i_cost_b;
        row_w   = {1'b0, mag_a} + {1'b0, mag_b};
        agree   = (sig_a_c == sig_b_c);

        sum_w   = {1'b0, r_weight} + (wsa_pkg::SUM_W+1)'(row_w);
        sum_m   = {1'b0, r_match} + (wsa_pkg::SUM_W+1)'(row_w);
        n_weight = sum_w[wsa_pkg::SUM_W] ? wsa_pkg::SUM_MAX : sum_w[wsa_pkg::SUM_W-1:0];
        if (agree) begin
            n_match = sum_m[wsa_pkg::SUM_W] ? wsa_pkg::SUM_MAX : sum_m[wsa_pkg::SUM_W-1:0];
        end else begin
            n_match = r_match;
        end
    end

    // A last row may only transfer when the divider is free to take its sums.
    assign o_ready = !div_busy || !i_last_row;
    assign xfer    = i_valid && o_ready;

    always_comb begin
        div_req.start  = xfer && i_last_row;
        div_req.match  = n_match;
        div_req.weight = n_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match  <= '0;
            r_weight <= '0;
        end else if (xfer) begin
            if (i_last_row) begin
                r_match  <= '0;
                r_weight <= '0;
            end else begin
                r_match  <= n_match;
                r_weight <= n_weight;
            end
        end
    end

    wsa_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (div_req),
        .i_ready       (i_ready),
        .o_busy        (div_busy),
        .o_valid       (o_valid),
        .o_similarity  (o_similarity),
        .o_zero_weight (o_zero_weight)
    );

    a_match_le_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match <= r_weight)
        else $error("match sum exceeds weight sum");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_last_row |=> (r_match == '0) && (r_weight == '0))
        else $error("sums not cleared after last row");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_last_row |=> div_busy && !o_valid)
        else $error("divider did not start on last row");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_weight |-> o_similarity == '0)
        else $error("zero weight with nonzero similarity");

endmodule
`default_nettype wire
